// File: rtl/slfd_pkg.sv
`timescale 1ns / 1ps
// slfd_pkg: shared types and constants for the sync/length frame deframer
// no dependencies

package slfd_pkg;

  // header layout
  localparam int unsigned AddrBytes = 6;
  localparam int unsigned AddrW     = 8 * AddrBytes;
  localparam int unsigned AddrCntW  = 3;

  // register reset values
  localparam logic [7:0] SyncFirstRst  = 8'd251;
  localparam logic [7:0] SyncSecondRst = 8'd63;
  localparam logic [7:0] SyncThirdRst  = 8'd114;

  // register indexes (word address bits)
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_SYNC_THIRD  = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  // deframer phase
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_HUNT3   = 3'd2,
    PH_ADDR    = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

endpackage

// File: rtl/sync_length_frame_deframer.sv
`timescale 1ns / 1ps
// sync_length_frame_deframer: hunts a three-byte start pattern, captures the
// source address and length, and emits tagged payload bytes
// depends on slfd_pkg
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   rx      | in        | rx_valid_i/rx_ready_o  | rx_byte_i
//   res     | out       | res_valid_o/res_ready_i| payload_byte_o, byte_index_o,
//           |           |                        | frame_length_o, source_address_o,
//           |           |                        | last_byte_o, empty_frame_o
//   cfg     | in        | apb psel/penable       | paddr, pwdata, prdata
//
// one byte per clock while rx_ready_o is high; every taken byte passes the
// next-state logic into the state registers and the result register, so a
// result appears in the cycle after its byte is taken
// rx_ready_o is high while the result register is empty or being drained
// a stalled result holds the input side only when the result register is full
// reset puts the block in the hunt phase with the default start pattern

module sync_length_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // result output
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  byte_index_o,
  output logic [7:0]  frame_length_o,
  output logic [47:0] source_address_o,
  output logic        last_byte_o,
  output logic        empty_frame_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] sync_first_q, sync_second_q, sync_third_q;

  slfd_pkg::phase_e                 phase_q, phase_d;
  logic [slfd_pkg::AddrW-1:0]       addr_q, addr_d;
  logic [slfd_pkg::AddrCntW-1:0]    addr_cnt_q, addr_cnt_d;
  logic [7:0]                       decl_len_q, decl_len_d;
  logic [7:0]                       pay_cnt_q, pay_cnt_d;

  logic        res_valid_q;
  logic [7:0]  res_byte_q, res_idx_q, res_len_q;
  logic [47:0] res_addr_q;
  logic        res_last_q, res_empty_q;

  logic        rx_fire;
  logic        emit;
  logic [7:0]  emit_byte, emit_idx, emit_len;
  logic        emit_last, emit_empty;
  logic        pay_last;
  slfd_pkg::phase_e hunt_next;
  slfd_pkg::reg_idx_e reg_sel;
  logic        cfg_wr;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = slfd_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= slfd_pkg::SyncFirstRst;
      sync_second_q <= slfd_pkg::SyncSecondRst;
      sync_third_q  <= slfd_pkg::SyncThirdRst;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        slfd_pkg::REG_SYNC_FIRST:  sync_first_q  <= pwdata[7:0];
        slfd_pkg::REG_SYNC_SECOND: sync_second_q <= pwdata[7:0];
        slfd_pkg::REG_SYNC_THIRD:  sync_third_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      slfd_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_q};
      slfd_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_q};
      slfd_pkg::REG_SYNC_THIRD:  prdata = {24'd0, sync_third_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // input handshake
  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  // a mismatched start byte is rechecked as a first start byte
  assign hunt_next = (rx_byte_i == sync_first_q) ? slfd_pkg::PH_HUNT2 : slfd_pkg::PH_HUNT1;
  assign pay_last  = ({1'b0, pay_cnt_q} + 9'd1) >= {1'b0, decl_len_q};

  // next state and result
  always_comb begin
    phase_d    = phase_q;
    addr_d     = addr_q;
    addr_cnt_d = addr_cnt_q;
    decl_len_d = decl_len_q;
    pay_cnt_d  = pay_cnt_q;
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_idx   = 8'd0;
    emit_len   = 8'd0;
    emit_last  = 1'b0;
    emit_empty = 1'b0;
    unique case (phase_q)
      slfd_pkg::PH_HUNT2: begin
        phase_d = (rx_byte_i == sync_second_q) ? slfd_pkg::PH_HUNT3 : hunt_next;
      end
      slfd_pkg::PH_HUNT3: begin
        if (rx_byte_i == sync_third_q) begin
          phase_d    = slfd_pkg::PH_ADDR;
          addr_cnt_d = '0;
        end else begin
          phase_d = hunt_next;
        end
      end
      slfd_pkg::PH_ADDR: begin
        addr_d     = {addr_q[slfd_pkg::AddrW-9:0], rx_byte_i};
        addr_cnt_d = addr_cnt_q + 3'd1;
        if (addr_cnt_d >= slfd_pkg::AddrCntW'(slfd_pkg::AddrBytes)) begin
          phase_d = slfd_pkg::PH_LEN;
        end
      end
      slfd_pkg::PH_LEN: begin
        decl_len_d = rx_byte_i;
        pay_cnt_d  = 8'd0;
        if (rx_byte_i == 8'd0) begin
          // zero length: one empty result, then hunt again
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_empty = 1'b1;
          phase_d    = slfd_pkg::PH_HUNT1;
          addr_cnt_d = '0;
        end else begin
          phase_d = slfd_pkg::PH_PAYLOAD;
        end
      end
      slfd_pkg::PH_PAYLOAD: begin
        emit      = 1'b1;
        emit_byte = rx_byte_i;
        emit_idx  = pay_cnt_q;
        emit_len  = decl_len_q;
        emit_last = pay_last;
        if (pay_last) begin
          phase_d    = slfd_pkg::PH_HUNT1;
          addr_cnt_d = '0;
          pay_cnt_d  = 8'd0;
        end else begin
          pay_cnt_d = pay_cnt_q + 8'd1;
        end
      end
      default: begin
        phase_d = hunt_next;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= slfd_pkg::PH_HUNT1;
      addr_q     <= '0;
      addr_cnt_q <= '0;
      decl_len_q <= 8'd0;
      pay_cnt_q  <= 8'd0;
    end else if (rx_fire) begin
      phase_q    <= phase_d;
      addr_q     <= addr_d;
      addr_cnt_q <= addr_cnt_d;
      decl_len_q <= decl_len_d;
      pay_cnt_q  <= pay_cnt_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      res_valid_q <= rx_fire && emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (rx_fire && emit) begin
      res_byte_q  <= emit_byte;
      res_idx_q   <= emit_idx;
      res_len_q   <= emit_len;
      res_addr_q  <= addr_q;
      res_last_q  <= emit_last;
      res_empty_q <= emit_empty;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign payload_byte_o   = res_byte_q;
  assign byte_index_o     = res_idx_q;
  assign frame_length_o   = res_len_q;
  assign source_address_o = res_addr_q;
  assign last_byte_o      = res_last_q;
  assign empty_frame_o    = res_empty_q;

`ifndef NO_ASSERTIONS
  // empty frame result is always the last one and carries zero data
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_empty_q |-> res_last_q && res_byte_q == 8'd0 && res_len_q == 8'd0)
    else $error("empty frame result malformed");

  // payload index stays below the declared length
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_empty_q |-> res_idx_q < res_len_q)
    else $error("payload index beyond frame length");

  // last payload byte sits at the final index
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_empty_q && res_last_q |-> res_idx_q == res_len_q - 8'd1)
    else $error("last flag at wrong index");

  // address counter never passes the header size
  a_addr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == slfd_pkg::PH_ADDR |-> addr_cnt_q < 3'(slfd_pkg::AddrBytes))
    else $error("address counter overrun");

  // sixth address byte moves to the length phase
  a_addr_to_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && phase_q == slfd_pkg::PH_ADDR && addr_cnt_q == 3'(slfd_pkg::AddrBytes - 1)
    |=> phase_q == slfd_pkg::PH_LEN)
    else $error("missed length phase");
`endif

endmodule
